>>> src/xo64ds_pkg.sv
// ----------------------------------------------------------------------------
// xo64ds_pkg
// Types and constants for the xoroshiro64** dual-stream seeder.
// ----------------------------------------------------------------------------
package xo64ds_pkg;

  localparam logic [31:0] XoMult       = 32'h9e3779bb;
  localparam logic [31:0] XoOutMult    = 32'd5;
  localparam int unsigned XoRotA       = 26;
  localparam int unsigned XoShiftB     = 9;
  localparam int unsigned XoRotC       = 13;
  localparam int unsigned XoRotScr     = 5;
  localparam int unsigned XoMaxRounds  = 4;
  localparam int unsigned XoRoundW     = $clog2(XoMaxRounds);

  typedef struct packed {
    logic [31:0] seed_word_low;
    logic [31:0] seed_word_high;
  } seed_t;

  typedef struct packed {
    logic [31:0] stream_one_s0;
    logic [31:0] stream_one_s1;
    logic [31:0] stream_two_s0;
    logic [31:0] stream_two_s1;
    logic        seed_rejected;
  } streams_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMulA = 4'b0010,
    StMulB = 4'b0100,
    StOut  = 4'b1000
  } xo_state_e;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned k);
    logic [63:0] w;
    w = {v, v} << k;
    return w[63:32];
  endfunction

endpackage

>>> src/xoroshiro64_dual_stream_seeder_unit.sv
// ----------------------------------------------------------------------------
// xoroshiro64_dual_stream_seeder_unit
// Turns a 64-bit seed into two xoroshiro64** stream states.
// ----------------------------------------------------------------------------
// Usage:
//   The seed channel (seed_valid_i / seed_ready_o) takes one beat holding two
//   32-bit seed words. The streams channel (streams_valid_o / streams_ready_i)
//   returns one beat per seed with both stream states and a reject flag.
//   An all-zero seed returns the flag set and all state words zero, after
//   which the source should supply a fresh seed.
//   A nonzero seed runs generator rounds on one shared 32x32 multiplier,
//   two multiplies per generator step and two steps per round. One round
//   always suffices for a nonzero seed; a zero seed skips the rounds and
//   goes straight to the output state. The hardware bounds the round
//   count at four.
//   The block takes one seed at a time: seed_ready_o is high only while the
//   sequencer is idle. A finished result sits in an output register, so a
//   new seed may be taken while the previous result waits; if the receiver
//   is still stalling when the next result is ready, the sequencer holds it.
//   Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module xoroshiro64_dual_stream_seeder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xo64ds_pkg::seed_t    seed_i,
  input  logic              seed_valid_i,
  output logic              seed_ready_o,
  output xo64ds_pkg::streams_t streams_o,
  output logic              streams_valid_o,
  input  logic              streams_ready_i
);
  import xo64ds_pkg::*;

  xo_state_e            state_q, state_d;
  logic [31:0]          s0_q, s1_q, p_q, o0_q, o1_q;
  logic                 second_q;
  logic [XoRoundW-1:0]  round_q;
  logic                 rej_q;
  streams_t             out_q;
  logic                 out_valid_q;

  logic [31:0] mul_a, mul_b, mul_y;
  logic [31:0] adv_t, adv_s0, adv_s1;
  logic        seed_acc, out_free, last_round;

  assign seed_ready_o    = (state_q == StIdle);
  assign seed_acc        = seed_valid_i && seed_ready_o;
  assign out_free        = !out_valid_q || streams_ready_i;
  assign streams_o       = out_q;
  assign streams_valid_o = out_valid_q;
  assign last_round      = (round_q == XoRoundW'(XoMaxRounds - 1));

  // The one multiplier: the constant multiply of the scrambler in the first
  // phase, the multiply by five of the rotated product in the second.
  always_comb begin
    if (state_q == StMulB) begin
      mul_a = rotl32(p_q, XoRotScr);
      mul_b = XoOutMult;
    end else begin
      mul_a = s0_q;
      mul_b = XoMult;
    end
    mul_y = mul_a * mul_b;
  end

  always_comb begin
    adv_t  = s0_q ^ s1_q;
    adv_s0 = rotl32(s0_q, XoRotA) ^ adv_t ^ (adv_t << XoShiftB);
    adv_s1 = rotl32(adv_t, XoRotC);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (seed_acc) begin
          if ((seed_i.seed_word_low | seed_i.seed_word_high) == 32'd0) begin
            state_d = StOut;
          end else begin
            state_d = StMulA;
          end
        end
      end
      StMulA: state_d = StMulB;
      StMulB: begin
        if (second_q && (((o0_q | mul_y) != 32'd0) || last_round)) begin
          state_d = StOut;
        end else begin
          state_d = StMulA;
        end
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
      round_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (streams_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (seed_acc) begin
        second_q <= 1'b0;
        round_q  <= '0;
      end else if (state_q == StMulB) begin
        second_q <= !second_q;
        if (second_q) begin
          round_q <= round_q + 1'b1;
        end
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (seed_acc) begin
      o0_q <= 32'd0;
      o1_q <= 32'd0;
      if ((seed_i.seed_word_low | seed_i.seed_word_high) == 32'd0) begin
        // A rejected seed reports all state words as zero.
        s0_q  <= 32'd0;
        s1_q  <= 32'd0;
        rej_q <= 1'b1;
      end else begin
        s0_q  <= seed_i.seed_word_low;
        s1_q  <= seed_i.seed_word_high;
        rej_q <= 1'b0;
      end
    end
    if (state_q == StMulA) begin
      p_q <= mul_y;
    end
    if (state_q == StMulB) begin
      s0_q <= adv_s0;
      s1_q <= adv_s1;
      if (second_q) begin
        o1_q <= mul_y;
      end else begin
        o0_q <= mul_y;
      end
    end
    if (state_q == StOut && out_free) begin
      out_q.stream_one_s0 <= s0_q;
      out_q.stream_one_s1 <= s1_q;
      out_q.stream_two_s0 <= o0_q;
      out_q.stream_two_s1 <= o1_q;
      out_q.seed_rejected <= rej_q;
    end
  end

endmodule
